// ===== src/sha256_pkg.sv =====
// Package with SHA-256 types, constants and round functions shared by the hasher modules.
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Block assembled by the front end and handed to the compression engine.
  typedef struct packed {
    logic [511:0] data;    // big-endian block, byte 0 in bits 511:504
    logic         emit;    // final block of a message: emit digest, then reinit
  } blk_t;

  typedef enum logic [1:0] {
    FE_ABSORB,
    FE_PAD,
    FE_LEN
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_ROUND,
    BE_ADD,
    BE_EMIT
  } be_state_e;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_s0(input word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== src/sha256_front.sv =====
// Front end: collects message bytes into blocks and builds the padding blocks.
module sha256_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  input  logic [7:0]         in_byte_i,
  output logic               blk_valid_o,
  input  logic               blk_ready_i,
  output sha256_pkg::blk_t   blk_o
);
  import sha256_pkg::*;

  fe_state_e    state_q, state_d;
  logic [511:0] buf_q, buf_d;
  logic [60:0]  total_q, total_d;
  logic [63:0]  bits_q, bits_d;
  logic         push;
  logic         push_emit;
  logic [5:0]   fill;
  logic [511:0] buf_next;

  assign fill = total_q[5:0];

  // Byte n lives at bits 511-8n.
  always_comb begin
    buf_next = buf_q;
    buf_next[511 - 8*fill -: 8] = in_byte_i;
  end

  always_comb begin
    state_d   = state_q;
    buf_d     = buf_q;
    total_d   = total_q;
    bits_d    = bits_q;
    push      = 1'b0;
    push_emit = 1'b0;
    blk_o.data = buf_q;
    in_ready_o = 1'b0;
    case (state_q)
      FE_ABSORB: begin
        in_ready_o = blk_ready_i;
        blk_o.data = buf_next;
        if (in_valid_i && in_ready_o) begin
          if (in_op_i == OP_ABSORB) begin
            buf_d   = buf_next;
            total_d = total_q + 61'd1;
            if (fill == 6'd63) push = 1'b1;
          end else begin
            bits_d = {total_q, 3'b000};
            // Bytes after the marker are zeroed.
            for (int i = 0; i < 64; i++) begin
              if (i == int'(fill)) buf_d[511 - 8*i -: 8] = PAD_BYTE;
              else if (i > int'(fill)) buf_d[511 - 8*i -: 8] = 8'h00;
            end
            state_d = (fill >= 6'(LEN_POS)) ? FE_PAD : FE_LEN;
          end
        end
      end
      FE_PAD: begin
        push  = 1'b1;
        if (blk_ready_i) begin
          buf_d   = '0;
          state_d = FE_LEN;
        end
      end
      FE_LEN: begin
        blk_o.data = {buf_q[511:64], bits_q};
        push      = 1'b1;
        push_emit = 1'b1;
        if (blk_ready_i) begin
          total_d = '0;
          state_d = FE_ABSORB;
        end
      end
      default: state_d = FE_ABSORB;
    endcase
    blk_o.emit = push_emit;
  end

  assign blk_valid_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_ABSORB;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    bits_q <= bits_d;
  end

endmodule

// ===== src/sha256_queue.sv =====
// Two-entry block queue between the front end and the compression engine.
module sha256_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  sha256_pkg::blk_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output sha256_pkg::blk_t rd_data_o
);
  import sha256_pkg::*;

  blk_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== src/sha256_engine.sv =====
// Back end: 64-round compression, one round per cycle, and digest output.
module sha256_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             blk_valid_i,
  output logic             blk_ready_o,
  input  sha256_pkg::blk_t blk_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      out_word_o,
  output logic [2:0]       out_index_o,
  output logic             out_last_o
);
  import sha256_pkg::*;

  be_state_e  state_q, state_d;
  word_t      h_q [8];
  word_t      v_q [8];
  word_t      w_q [16];
  logic [5:0] rnd_q;
  logic       emit_q;
  logic [2:0] idx_q;
  word_t      t1, t2, wnew;

  assign t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + ROUND_K[rnd_q] + w_q[0];
  assign t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign wnew = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE:  if (blk_valid_i) state_d = BE_ROUND;
      BE_ROUND: if (rnd_q == 6'd63) state_d = BE_ADD;
      BE_ADD:   state_d = emit_q ? BE_EMIT : BE_IDLE;
      BE_EMIT:  if (out_ready_i && idx_q == 3'd7) state_d = BE_IDLE;
      default:  state_d = BE_IDLE;
    endcase
  end

  assign blk_ready_o = (state_q == BE_IDLE);
  assign out_valid_o = (state_q == BE_EMIT);
  assign out_word_o  = h_q[idx_q];
  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
      emit_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
    end else begin
      state_q <= state_d;
      case (state_q)
        BE_IDLE: if (blk_valid_i) begin
          rnd_q  <= '0;
          emit_q <= blk_i.emit;
        end
        BE_ROUND: rnd_q <= rnd_q + 6'd1;
        BE_ADD: begin
          idx_q <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        BE_EMIT: if (out_ready_i) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BE_IDLE && blk_valid_i) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i.data[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == BE_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  ap_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_ROUND && rnd_q == 6'd63) |=> state_q == BE_ADD)
    else $error("round count did not end in add");
  ap_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_ADD && emit_q) |=> (state_q == BE_EMIT && idx_q == 3'd0))
    else $error("digest output did not start at word zero");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_EMIT && !out_ready_i) |=> $stable(idx_q))
    else $error("digest index moved while stalled");

endmodule

// ===== src/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher: front end, block queue and compression engine.
// Output: a finish transaction yields the eight digest words once its final block is compressed;
// the padding takes an extra block when the marker falls at byte 56 or later.
// Throughput: one byte per cycle within a block; the engine's single round unit sets the rate
// of full blocks, so bytes stall when the queue fills.
// Reset (rst_ni, asynchronous, active low) restores the initial hash and a zero count.
module sha256_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  logic fq_valid, fq_ready, qe_valid, qe_ready;
  blk_t fq_blk, qe_blk;
  logic [31:0] word;
  logic [2:0]  idx;

  // The front end packs bytes and appends padding and the length.
  sha256_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .blk_valid_o(fq_valid),
    .blk_ready_i(fq_ready),
    .blk_o      (fq_blk)
  );

  // The queue lets the front end fill the next block while the engine runs.
  sha256_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_blk),
    .rd_valid_o(qe_valid), .rd_ready_i(qe_ready), .rd_data_o(qe_blk)
  );

  // The engine compresses each block and streams the digest on a final block.
  sha256_engine u_engine (
    .clk_i, .rst_ni,
    .blk_valid_i(qe_valid), .blk_ready_o(qe_ready), .blk_i(qe_blk),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(word), .out_index_o(idx), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, idx, word};

endmodule
